// File: design/png_scanline_unfilter_defines.svh
// Assertion macros shared by the unfilter checker.
// Needs a clk and an rst signal in the scope that uses them.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psu check failed");

// Consequent must hold in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psu check failed");

`endif

// File: design/psu_pkg.sv
// Package for the PNG scanline unfilter: field widths, register indexes,
// filter codes and the Paeth predictor. No dependencies.
`default_nettype none

package psu_pkg;

  localparam int ROW_LEN_W   = 14;
  localparam int STRIDE_W    = 3;
  localparam int IMG_ROWS_W  = 15;
  localparam int ROW_IDX_W   = 14;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int ROWS_LIMIT  = 16384;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 2'd2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // Paeth predictor: pick the neighbor closest to left + up - upper_left.
  function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                            input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] sa, sb, sc, da, db, dc;
    logic [7:0] pick;
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    sc = signed'({2'b00, c});
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) pick = a;
    else if (db <= dc)        pick = b;
    else                      pick = c;
    return pick;
  endfunction

endpackage

`default_nettype wire

// File: design/png_scanline_unfilter.sv
// PNG scanline unfilter, top level: row tracking, line buffer, predictor.
// Depends on psu_pkg.
//
// Usage
//   Input channel (stream_byte, in_valid, in_stall) carries the inflated
//   stream: per row one filter code, then row_length filtered bytes. A
//   filter code item gives no result. Each data item gives one result on
//   the output channel (pixel_byte, row_done, image_done, bad_filter,
//   out_valid, out_stall). row_done marks the last byte of a row,
//   image_done the last byte of the last row; the next item then starts a
//   new image whose first row has no row above.
//   Accepted items pass the compute stage, then the output register.
//   Throughput: one item per cycle while not stalled, set by the line buffer
//   doing one read (at accept) and one write (from the compute stage) in the same cycle.
//   A filter code above 4 gives one result with bad_filter set and
//   pixel_byte zero; after that all input is taken and dropped until reset.
//   Reset (rst, synchronous): registers go to 1, the block waits for a
//   filter code. The line buffer is not cleared and needs no clearing pass.
//   Stall: out_stall holds the output register; the compute stage then holds and
//   in_stall rises in the same cycle. The user writes configuration (cfg_write,
//   cfg_index, cfg_data) only while the block is idle; the block does not enforce it.
`default_nettype none

module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES    = 8192,
  parameter int MAX_PIXEL_STRIDE = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  // configuration write port
  input  wire                               cfg_write,
  input  wire  [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [psu_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [7:0]                        stream_byte,
  // output channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [7:0]                        pixel_byte,
  output logic                              row_done,
  output logic                              image_done,
  output logic                              bad_filter
);

  import psu_pkg::*;

  localparam int AW   = $clog2(MAX_ROW_BYTES);
  localparam int LW0  = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMPW = (LW0 > ROW_LEN_W) ? LW0 : ROW_LEN_W;
  localparam int HIW  = (MAX_PIXEL_STRIDE > 1) ? $clog2(MAX_PIXEL_STRIDE) : 1;

  // configuration registers
  logic [ROW_LEN_W-1:0]  row_length;
  logic [STRIDE_W-1:0]   pixel_stride;
  logic [IMG_ROWS_W-1:0] image_rows;

  // front-end row tracking
  logic                  awaiting;
  logic                  halted;
  filter_t               filter_kind;
  logic [AW-1:0]         column_index;
  logic [ROW_IDX_W-1:0]  row_index;

  // compute stage
  logic                  s2_valid;
  logic                  s2_bad;
  logic [7:0]            s2_byte;
  logic [AW-1:0]         s2_col;
  filter_t               s2_filter;
  logic                  s2_first_row;
  logic                  s2_left_ok;
  logic [HIW-1:0]        s2_tap;
  logic                  s2_row_end;
  logic                  s2_image_end;
  logic                  s2_adv;

  // line buffer and neighbor history
  logic [7:0]            line_mem [MAX_ROW_BYTES];
  logic [7:0]            up_rd;
  logic [7:0]            left_hist [MAX_PIXEL_STRIDE];
  logic [7:0]            ul_hist   [MAX_PIXEL_STRIDE];

  // effective (clamped) settings
  logic [CMPW-1:0]       len_eff;
  logic [3:0]            stride_eff;
  logic [IMG_ROWS_W-1:0] rows_eff;

  logic                  accept;
  logic                  take_data;
  logic                  take_bad;
  logic [CMPW-1:0]       col_plus;
  logic                  row_end;
  logic [IMG_ROWS_W-1:0] row_plus;
  logic                  image_end;
  logic                  commit;

  logic [7:0]            up_b;
  logic [7:0]            left_b;
  logic [7:0]            ul_b;
  logic [8:0]            avg_sum;
  logic [7:0]            pred;
  logic [7:0]            val;

  // ---------------------------------------------------------------------
  // Settings: out-of-range values clamp to the nearest legal one.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [CMPW-1:0] rl;
    logic [3:0]      ps;
    rl = CMPW'(row_length);
    if (rl == '0)                          len_eff = CMPW'(1);
    else if (rl > CMPW'(MAX_ROW_BYTES))    len_eff = CMPW'(MAX_ROW_BYTES);
    else                                   len_eff = rl;

    ps = {1'b0, pixel_stride};
    if (ps == 4'd0)                        stride_eff = 4'd1;
    else if (ps > 4'(MAX_PIXEL_STRIDE))    stride_eff = 4'(MAX_PIXEL_STRIDE);
    else                                   stride_eff = ps;

    if (image_rows == '0)                  rows_eff = IMG_ROWS_W'(1);
    else if (image_rows > IMG_ROWS_W'(ROWS_LIMIT)) rows_eff = IMG_ROWS_W'(ROWS_LIMIT);
    else                                   rows_eff = image_rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= ROW_LEN_W'(1);
      pixel_stride <= STRIDE_W'(1);
      image_rows   <= IMG_ROWS_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_LENGTH:   row_length   <= cfg_data[ROW_LEN_W-1:0];
        REG_PIXEL_STRIDE: pixel_stride <= cfg_data[STRIDE_W-1:0];
        REG_IMAGE_ROWS:   image_rows   <= cfg_data[IMG_ROWS_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. Every accept coincides with the compute stage being empty
  // or moving on, so the line buffer write of one item always lands no
  // later than the read of any later item: no forwarding is needed.
  // ---------------------------------------------------------------------
  assign s2_adv   = !out_valid || !out_stall;
  assign in_stall = s2_valid && !s2_adv;
  assign accept   = in_valid && !in_stall;

  assign take_bad  = accept && !halted && awaiting && (stream_byte > 8'(FILT_PAETH));
  assign take_data = accept && !halted && !awaiting;

  assign col_plus  = CMPW'(column_index) + CMPW'(1);
  assign row_end   = col_plus >= len_eff;
  assign row_plus  = IMG_ROWS_W'(row_index) + IMG_ROWS_W'(1);
  assign image_end = row_end && (row_plus >= rows_eff);

  // Front end: filter codes, column and row counting, all known at accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting     <= 1'b1;
      halted       <= 1'b0;
      filter_kind  <= FILT_NONE;
      column_index <= '0;
      row_index    <= '0;
    end else if (accept && !halted) begin
      if (awaiting) begin
        if (take_bad) begin
          halted <= 1'b1;
        end else begin
          filter_kind  <= filter_t'(stream_byte[2:0]);
          awaiting     <= 1'b0;
          column_index <= '0;
        end
      end else begin
        if (row_end) begin
          column_index <= '0;
          awaiting     <= 1'b1;
          row_index    <= image_end ? '0 : row_plus[ROW_IDX_W-1:0];
        end else begin
          column_index <= col_plus[AW-1:0];
        end
      end
    end
  end

  // Compute stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (take_data || take_bad) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  // Compute stage payload; line buffer read issued on the same edge.
  always_ff @(posedge clk) begin
    if (take_data || take_bad) begin
      s2_bad       <= take_bad;
      s2_byte      <= stream_byte;
      s2_col       <= column_index;
      s2_filter    <= filter_kind;
      s2_first_row <= (row_index == '0);
      s2_left_ok   <= CMPW'(column_index) >= CMPW'(stride_eff);
      s2_tap       <= HIW'(stride_eff - 4'd1);
      s2_row_end   <= row_end;
      s2_image_end <= image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take_data) begin
      up_rd <= line_mem[column_index];
    end
    if (commit) begin
      line_mem[s2_col] <= val;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor. Left and upper-left come from short byte histories that
  // only hold bytes of the current row when the tap is in range.
  // ---------------------------------------------------------------------
  assign commit = s2_valid && s2_adv && !s2_bad;

  always_comb begin
    up_b    = s2_first_row ? 8'd0 : up_rd;
    left_b  = s2_left_ok ? left_hist[s2_tap] : 8'd0;
    ul_b    = s2_left_ok ? ul_hist[s2_tap]   : 8'd0;
    avg_sum = {1'b0, left_b} + {1'b0, up_b};
    case (s2_filter)
      FILT_SUB:   pred = left_b;
      FILT_UP:    pred = up_b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pick(left_b, up_b, ul_b);
      default:    pred = 8'd0;
    endcase
    val = s2_byte + pred;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      left_hist[0] <= val;
      ul_hist[0]   <= up_b;
      for (int i = 1; i < MAX_PIXEL_STRIDE; i++) begin
        left_hist[i] <= left_hist[i-1];
        ul_hist[i]   <= ul_hist[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: hold while stalled, advance otherwise.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid) begin
      pixel_byte <= s2_bad ? 8'd0 : val;
      row_done   <= !s2_bad && s2_row_end;
      image_done <= !s2_bad && s2_image_end;
      bad_filter <= s2_bad;
    end
  end

endmodule

`default_nettype wire

// File: design/psu_checker.sv
// Port-level checks for the PNG scanline unfilter, bound to the top level.
// Depends on png_scanline_unfilter_defines.svh.
`default_nettype none

`include "png_scanline_unfilter_defines.svh"

module psu_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] pixel_byte,
  input wire       row_done,
  input wire       image_done,
  input wire       bad_filter
);

  logic [10:0] out_word;

  assign out_word = {pixel_byte, row_done, image_done, bad_filter};

  // a stalled result holds
  `PSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // the error result carries nothing else
  `PSU_ASSERT_SAME(a_bad_clean, out_valid && bad_filter, pixel_byte == 8'd0 && !row_done && !image_done)

  // an image ends only at a row end
  `PSU_ASSERT_SAME(a_image_row, out_valid && image_done, row_done)

  // nothing follows the error result
  `PSU_ASSERT_NEXT(a_bad_last, out_valid && bad_filter && !out_stall, !out_valid)

  // input is never held off while the output side is free
  `PSU_ASSERT_SAME(a_no_idle_stall, !out_valid, !in_stall)

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_byte (pixel_byte),
  .row_done   (row_done),
  .image_done (image_done),
  .bad_filter (bad_filter)
);

`default_nettype wire

// File: dv/png_scanline_unfilter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for png_scanline_unfilter: random scanline streams
// against an in-bench unfilter model. Depends on psu_pkg and the block RTL.

module png_scanline_unfilter_tb;
  import psu_pkg::*;

  localparam int MAX_ROW_BYTES  = 8192;
  localparam int MAX_STRIDE     = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 80;
  localparam int RANDOM_ITEMS   = 1850;
  // Row that writes every column the random phases can reach, and how many
  // of its bytes go out before its length is cut to size.
  localparam int PRIME_LEN      = 64;
  localparam int OPEN_BYTES     = 40;
  // Index 3 is outside the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } pixel_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            stream_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            pixel_byte;
  logic                  row_done;
  logic                  image_done;
  logic                  bad_filter;

  png_scanline_unfilter uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_byte  (pixel_byte),
    .row_done    (row_done),
    .image_done  (image_done),
    .bad_filter  (bad_filter)
  );

  always #5 clk = ~clk;

  // Stimulus backlog and expected pixel results.
  logic [7:0]    byte_backlog[$];
  pixel_result_t pending_pixels[$];
  pixel_result_t next_pixel;

  // Shared controls: idle bursts on/off, long receiver hold requests.
  bit idle_on = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int error_count = 0;

  // ---------------------------------------------------------------------
  // Unfilter model state: register copies and the row tracking the block
  // keeps. The first PRIME_LEN columns of the line buffer are written by a
  // full row early in the run and random row lengths never go past them,
  // so later mid-image growth never reads an unwritten entry.
  // ---------------------------------------------------------------------
  logic [13:0] row_length_reg = 14'd1;
  logic [2:0]  stride_reg = 3'd1;
  logic [14:0] rows_reg = 15'd1;

  logic [7:0]  prior_row[MAX_ROW_BYTES];
  logic [31:0] left_bytes = '0;
  logic [31:0] upper_left_bytes = '0;
  int unsigned column = 0;
  int unsigned row_number = 0;
  filter_t     row_filter = FILT_NONE;
  bit          want_filter_code = 1'b1;
  bit          stream_halted = 1'b0;

  task automatic flag_error(input string msg);
    if (error_count < 200)
      $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int unsigned active_row_length();
    if (row_length_reg == 0) return 1;
    if (row_length_reg > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return row_length_reg;
  endfunction

  function automatic int abs_diff(input int x, input int y);
    return (x > y) ? x - y : y - x;
  endfunction

  // Advance the model by one accepted item; queue the result it causes.
  function automatic void unfilter_byte(input logic [7:0] b);
    int unsigned   len_eff, stride_eff, rows_eff, col;
    logic [7:0]    left, up, upleft, pred, val;
    logic [8:0]    sum9;
    int            p;
    pixel_result_t res;
    len_eff = active_row_length();
    stride_eff = (stride_reg == 0) ? 1 : (stride_reg > MAX_STRIDE) ? MAX_STRIDE : stride_reg;
    rows_eff = (rows_reg == 0) ? 1 : (rows_reg > ROWS_LIMIT) ? ROWS_LIMIT : rows_reg;
    res = '0;
    if (stream_halted) return;
    if (want_filter_code) begin
      // Unknown filter code: one error result, then drop everything.
      if (b > FILT_PAETH) begin
        stream_halted = 1'b1;
        res.bad = 1'b1;
        pending_pixels.push_back(res);
        return;
      end
      row_filter = filter_t'(b[2:0]);
      want_filter_code = 1'b0;
      column = 0;
      left_bytes = '0;
      upper_left_bytes = '0;
      return;
    end
    col = column;
    // No row above on the first row of an image.
    up = (row_number == 0) ? 8'h00 : prior_row[col];
    // Left neighbors are zero inside the first pixel.
    if (col >= stride_eff) begin
      left = left_bytes[8*(stride_eff-1) +: 8];
      upleft = upper_left_bytes[8*(stride_eff-1) +: 8];
    end else begin
      left = 8'h00;
      upleft = 8'h00;
    end
    case (row_filter)
      FILT_SUB:  pred = left;
      FILT_UP:   pred = up;
      FILT_AVG: begin
        sum9 = {1'b0, left} + {1'b0, up};
        pred = sum9[8:1];
      end
      FILT_PAETH: begin
        p = int'(left) + int'(up) - int'(upleft);
        if (abs_diff(p, left) <= abs_diff(p, up) && abs_diff(p, left) <= abs_diff(p, upleft))
          pred = left;
        else if (abs_diff(p, up) <= abs_diff(p, upleft))
          pred = up;
        else
          pred = upleft;
      end
      default:   pred = 8'h00;
    endcase
    val = b + pred;
    prior_row[col] = val;
    left_bytes = {left_bytes[23:0], val};
    upper_left_bytes = {upper_left_bytes[23:0], up};
    column = col + 1;
    res.pixel = val;
    // Current length and row count apply at once, even mid-row.
    if (column >= len_eff) begin
      res.row_end = 1'b1;
      column = 0;
      want_filter_code = 1'b1;
      row_number++;
      if (row_number >= rows_eff) begin
        res.image_end = 1'b1;
        row_number = 0;
      end
    end
    pending_pixels.push_back(res);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer backlog items, hold a stalled item, insert idle bursts.
  // The model advances on the accepting edge, so results line up in order.
  // ---------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        unfilter_byte(stream_byte);
      // Hold the offered item until the block takes it.
      if (!(in_valid && in_stall)) begin
        if (send_gap == 0 && idle_on && byte_backlog.size() != 0 && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 14);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          in_valid <= 1'b1;
          stream_byte <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest expectation and
  // drive out_stall, with random bursts and on request one long hold that
  // lets the pipeline fill and push back on the input.
  // ---------------------------------------------------------------------
  int recv_hold = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          flag_error($sformatf("result with nothing expected: pixel %02h", pixel_byte));
        end else begin
          next_pixel = pending_pixels.pop_front();
          if (pixel_byte !== next_pixel.pixel)
            flag_error($sformatf("pixel_byte %02h, want %02h", pixel_byte, next_pixel.pixel));
          if (row_done !== next_pixel.row_end)
            flag_error($sformatf("row_done %b, want %b", row_done, next_pixel.row_end));
          if (image_done !== next_pixel.image_end)
            flag_error($sformatf("image_done %b, want %b", image_done, next_pixel.image_end));
          if (bad_filter !== next_pixel.bad)
            flag_error($sformatf("bad_filter %b, want %b", bad_filter, next_pixel.bad));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        recv_hold = LONG_HOLD;
      end else if (recv_hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        recv_hold = $urandom_range(1, 14);
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ROW_LENGTH:   row_length_reg = data[13:0];
      REG_PIXEL_STRIDE: stride_reg = data[2:0];
      REG_IMAGE_ROWS:   rows_reg = data[14:0];
      default: ;
    endcase
  endtask

  // Wait until the backlog is sent and every result is in, then let the
  // pipeline drain a filter code that causes no result.
  task automatic settle();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Queue well-formed scanline content: a filter code wherever the block
  // expects one, random filtered bytes elsewhere, starting from the model's
  // current position in the row.
  task automatic queue_scanlines(input int count);
    bit          need_code;
    int unsigned col, len;
    logic [7:0]  b;
    @(negedge clk);
    need_code = want_filter_code;
    col = column;
    len = active_row_length();
    repeat (count) begin
      if (need_code) begin
        b = 8'($urandom_range(FILT_NONE, FILT_PAETH));
        need_code = 1'b0;
        col = 0;
      end else begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        col++;
        if (col >= len) need_code = 1'b1;
      end
      byte_backlog.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  logic [7:0] single_byte_rows[10] = '{
    8'(FILT_NONE), 8'h00, 8'(FILT_SUB), 8'hFF, 8'(FILT_UP), 8'h80,
    8'(FILT_AVG), 8'h7F, 8'(FILT_PAETH), 8'h55};
  logic [7:0] two_row_image[20] = '{
    8'(FILT_PAETH), 8'h10, 8'h20, 8'hF0, 8'h05,
    8'(FILT_PAETH), 8'hFF, 8'h01, 8'h80, 8'h7F,
    8'(FILT_AVG), 8'h01, 8'h02, 8'hFE, 8'h81,
    8'(FILT_SUB), 8'hAA, 8'h55, 8'h00, 8'hFF};
  int random_items = 0;
  int phase = 0;
  int count;
  logic [CFG_DATA_W-1:0] new_len, new_rows;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Reset registers: one-byte rows, one-row images, every filter kind.
    @(negedge clk);
    foreach (single_byte_rows[i]) byte_backlog.push_back(single_byte_rows[i]);
    settle();

    // Zero registers behave as one; the unmapped index changes nothing.
    write_reg(REG_ROW_LENGTH, '0);
    write_reg(REG_PIXEL_STRIDE, '0);
    write_reg(REG_IMAGE_ROWS, '0);
    write_reg(REG_UNUSED, '1);
    @(negedge clk);
    byte_backlog.push_back(8'(FILT_PAETH));
    byte_backlog.push_back(8'hAA);
    settle();

    // Four-byte rows, two-row image: up and upper-left come into play,
    // then a second image starts with no row above.
    write_reg(REG_ROW_LENGTH, 15'd4);
    write_reg(REG_PIXEL_STRIDE, 15'd2);
    write_reg(REG_IMAGE_ROWS, 15'd2);
    @(negedge clk);
    foreach (two_row_image[i]) byte_backlog.push_back(two_row_image[i]);
    settle();

    // An oversized length clamps to the line buffer size and an oversized
    // stride clamps to four: the open row does not end early. A shorter
    // length then ends it, having written every column the random phases
    // reach. Hold the receiver while the sender keeps offering, so the
    // block fills and stalls its input.
    write_reg(REG_ROW_LENGTH, 15'h3FFF);
    write_reg(REG_PIXEL_STRIDE, 15'd7);
    write_reg(REG_IMAGE_ROWS, 15'd1);
    hold_requests++;
    queue_scanlines(OPEN_BYTES + 1);
    settle();
    write_reg(REG_ROW_LENGTH, CFG_DATA_W'(PRIME_LEN));
    queue_scanlines(PRIME_LEN - OPEN_BYTES);
    settle();

    // Random phases. Registers change between phases, often mid-row or
    // mid-image; each phase pauses the sender until all results are in.
    while (random_items < RANDOM_ITEMS) begin
      idle_on = (random_items < RANDOM_ITEMS - 300) && (phase % 5 != 3);
      if (phase == 6) hold_requests++;
      case ($urandom_range(0, 9))
        0:       new_len = '0;
        1:       new_len = CFG_DATA_W'($urandom_range(13, PRIME_LEN));
        default: new_len = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       new_rows = '0;
        1:       new_rows = 15'h7FFF;
        default: new_rows = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 2) != 0) write_reg(REG_ROW_LENGTH, new_len);
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_PIXEL_STRIDE, CFG_DATA_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 2) != 0) write_reg(REG_IMAGE_ROWS, new_rows);
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
      count = $urandom_range(20, 120);
      queue_scanlines(count);
      random_items += count;
      settle();
      phase++;
    end

    // Finish the current row, then send an unknown filter code: one error
    // result, after which the block takes and drops every item.
    idle_on = 1'b0;
    if (!want_filter_code)
      queue_scanlines((column >= active_row_length()) ? 1 : active_row_length() - column);
    @(negedge clk);
    byte_backlog.push_back(8'($urandom_range(FILT_PAETH + 1, 255)));
    repeat (12) byte_backlog.push_back(8'($urandom_range(0, 255)));
    settle();

    // Let any late result show up before closing the books.
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", pending_pixels.size()));
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
